/* hdl/qsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types, codes and helpers for the quoted string unescape unit.
// ----------------------------------------------------------------------------
package qsu_pkg;

    // Decoder mode, one-hot
    typedef enum logic [3:0] {
        M_PASS   = 4'b0001,
        M_QUOTED = 4'b0010,
        M_ESC    = 4'b0100,
        M_HEX    = 4'b1000
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  digits;
        logic [15:0] code;
    } state_t;

    // One result word as it sits in the result queue
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       err;
    } entry_t;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [15:0] LIM_CTRL  = 16'h0020;
    localparam logic [15:0] LIM_ONE   = 16'h0080;
    localparam logic [15:0] LIM_TWO   = 16'h0800;
    localparam logic [7:0]  LEAD_TWO  = 8'hc0;
    localparam logic [7:0]  LEAD_THR  = 8'he0;
    localparam logic [7:0]  CONT_MARK = 8'h80;
    localparam logic [5:0]  CONT_MASK = 6'h3f;

    // Returns {is_hex, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] d);
        logic [4:0] r;
        r = 5'b0_0000;
        if (d >= 8'h30 && d <= 8'h39)
        begin
            r = {1'b1, d[3:0]};
        end
        else if ((d >= 8'h61 && d <= 8'h66) || (d >= 8'h41 && d <= 8'h46))
        begin
            r = {1'b1, d[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* hdl/qsu_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_decode
// Next-state and result list for one input byte, given the current mode.
// ----------------------------------------------------------------------------
module qsu_decode (
    input  logic [7:0]                  data_byte,
    input  logic                        first_byte,
    input  logic                        last_byte,
    input  qsu_pkg::state_t             state,
    output qsu_pkg::state_t             state_next,
    output logic [2:0]                  res_cnt,
    output qsu_pkg::entry_t [3:0]       res_list
);
    import qsu_pkg::*;

    logic [4:0]   hv;
    logic [15:0]  code_shift;
    logic [2:0]   digits_inc;
    logic         use_flush;
    logic [15:0]  flush_val;
    logic         extra_en;
    logic [7:0]   extra_byte;
    entry_t [2:0] flush_ent;
    logic [1:0]   flush_cnt;
    entry_t       extra_ent;
    logic         extra_any;

    assign hv         = hex_val(data_byte);
    assign code_shift = {state.code[11:0], hv[3:0]};
    assign digits_inc = state.digits + 3'd1;

    always_comb
    begin
        state_next = state;
        use_flush  = 1'b0;
        flush_val  = state.code;
        extra_en   = 1'b0;
        extra_byte = data_byte;
        if (first_byte)
        begin
            state_next.digits = 3'd0;
            state_next.code   = 16'h0000;
            if (data_byte == CH_DQUOTE || data_byte == CH_SQUOTE)
            begin
                state_next.mode = M_QUOTED;
            end
            else
            begin
                state_next.mode = M_PASS;
                extra_en        = 1'b1;
            end
        end
        else
        begin
            case (state.mode)
                M_PASS:
                begin
                    extra_en = 1'b1;
                end
                M_QUOTED:
                begin
                    if (!last_byte && data_byte == CH_BSLASH)
                    begin
                        state_next.mode = M_ESC;
                    end
                    else if (!last_byte)
                    begin
                        extra_en = 1'b1;
                    end
                end
                M_ESC:
                begin
                    state_next.mode = M_QUOTED;
                    if (data_byte == CH_N)
                    begin
                        extra_en   = 1'b1;
                        extra_byte = CH_LF;
                    end
                    else if (data_byte == CH_T)
                    begin
                        extra_en   = 1'b1;
                        extra_byte = CH_TAB;
                    end
                    else if (data_byte == CH_U)
                    begin
                        state_next.digits = 3'd0;
                        state_next.code   = 16'h0000;
                        if (last_byte)
                        begin
                            use_flush = 1'b1;
                            flush_val = 16'h0000;
                        end
                        else
                        begin
                            state_next.mode = M_HEX;
                        end
                    end
                    else
                    begin
                        extra_en = 1'b1;
                    end
                end
                M_HEX:
                begin
                    if (hv[4])
                    begin
                        if (digits_inc >= 3'd4 || last_byte)
                        begin
                            use_flush         = 1'b1;
                            flush_val         = code_shift;
                            state_next.digits = 3'd0;
                            state_next.code   = 16'h0000;
                            state_next.mode   = M_QUOTED;
                        end
                        else
                        begin
                            state_next.code   = code_shift;
                            state_next.digits = digits_inc;
                        end
                    end
                    else
                    begin
                        // end the escape early, then treat the byte as quoted text
                        use_flush         = 1'b1;
                        state_next.digits = 3'd0;
                        state_next.code   = 16'h0000;
                        state_next.mode   = M_QUOTED;
                        if (!last_byte && data_byte == CH_BSLASH)
                        begin
                            state_next.mode = M_ESC;
                        end
                        else if (!last_byte)
                        begin
                            extra_en = 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next.mode = M_PASS;
                end
            endcase
        end
        if (last_byte)
        begin
            state_next.mode   = M_PASS;
            state_next.digits = 3'd0;
            state_next.code   = 16'h0000;
        end
    end

    // UTF-8 encode of the collected value; a value below 0x20 gives an error entry
    always_comb
    begin
        flush_ent = '0;
        if (flush_val < LIM_CTRL)
        begin
            flush_cnt    = 2'd1;
            flush_ent[0] = '{data: 8'h00, valid: 1'b0, err: 1'b1};
        end
        else if (flush_val < LIM_ONE)
        begin
            flush_cnt    = 2'd1;
            flush_ent[0] = '{data: flush_val[7:0], valid: 1'b1, err: 1'b0};
        end
        else if (flush_val < LIM_TWO)
        begin
            flush_cnt    = 2'd2;
            flush_ent[0] = '{data: LEAD_TWO | {3'b000, flush_val[10:6]},
                             valid: 1'b1, err: 1'b0};
            flush_ent[1] = '{data: CONT_MARK | {2'b00, flush_val[5:0] & CONT_MASK},
                             valid: 1'b1, err: 1'b0};
        end
        else
        begin
            flush_cnt    = 2'd3;
            flush_ent[0] = '{data: LEAD_THR | {4'b0000, flush_val[15:12]},
                             valid: 1'b1, err: 1'b0};
            flush_ent[1] = '{data: CONT_MARK | {2'b00, flush_val[11:6]},
                             valid: 1'b1, err: 1'b0};
            flush_ent[2] = '{data: CONT_MARK | {2'b00, flush_val[5:0] & CONT_MASK},
                             valid: 1'b1, err: 1'b0};
        end
        if (!use_flush)
        begin
            flush_cnt = 2'd0;
        end
    end

    // A last byte with nothing else to say still yields an empty end marker
    assign extra_any = extra_en || (last_byte && !use_flush);
    assign extra_ent = extra_en ? entry_t'{data: extra_byte, valid: 1'b1, err: 1'b0}
                                : entry_t'('0);

    always_comb
    begin
        res_list = '0;
        case (flush_cnt)
            2'd0:
            begin
                res_list[0] = extra_ent;
            end
            2'd1:
            begin
                res_list[0] = flush_ent[0];
                res_list[1] = extra_ent;
            end
            2'd2:
            begin
                res_list[0] = flush_ent[0];
                res_list[1] = flush_ent[1];
                res_list[2] = extra_ent;
            end
            default:
            begin
                res_list[0] = flush_ent[0];
                res_list[1] = flush_ent[1];
                res_list[2] = flush_ent[2];
                res_list[3] = extra_ent;
            end
        endcase
        res_cnt = {1'b0, flush_cnt} + {2'b00, extra_any};
    end

endmodule

/* hdl/quoted_string_unescape_utf8_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescape_utf8_unit
// Streams token bytes, strips quotes, resolves escapes and emits UTF-8.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one token byte per word with
//   first_byte / last_byte marks. Output channel (out_valid / out_stall)
//   carries one decoded byte per word; run_end marks the final word caused by
//   an input byte, token_end marks every word caused by the last byte.
//   An input word is decoded in the cycle it is accepted; its results sit in
//   a four-entry result register and show from the next cycle on. Throughput:
//   one input word per cycle while out_stall is low and each word yields at
//   most one result. A word that yields n results (up to four, for a \u escape
//   that closes with a trailing byte) holds the input until all n have
//   drained, one word per cycle while out_stall is low. Words that yield no
//   result (an opening quote, a backslash, hex digits before the last) show
//   nothing. Reset clears the decoder mode to passthrough and empties the
//   result register. When the receiver stalls, the current output word holds
//   and in_stall rises once the result register cannot take another list.
// ----------------------------------------------------------------------------
module quoted_string_unescape_utf8_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       bad_escape,
    output logic       run_end,
    output logic       token_end
);
    import qsu_pkg::*;

    state_t       state_reg;
    state_t       state_next;
    logic [2:0]   cnt_reg;
    logic [2:0]   cnt_next;
    logic [1:0]   idx_reg;
    logic [1:0]   idx_next;
    entry_t [3:0] list_reg;
    entry_t [3:0] list_next;
    logic         tok_reg;
    logic [2:0]   dec_cnt;
    entry_t       head;
    logic         accept_in;
    logic         pop;
    logic         at_tail;

    qsu_decode u_decode (
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .state      (state_reg),
        .state_next (state_next),
        .res_cnt    (dec_cnt),
        .res_list   (list_next)
    );

    assign out_valid = (cnt_reg != 3'd0);
    assign at_tail   = (({1'b0, idx_reg} + 3'd1) == cnt_reg);
    assign pop       = out_valid && !out_stall;
    assign in_stall  = out_valid && !(pop && at_tail);
    assign accept_in = in_valid && !in_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (accept_in)
        begin
            cnt_next = dec_cnt;
            idx_next = 2'd0;
        end
        else if (pop)
        begin
            if (at_tail)
            begin
                cnt_next = 3'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: M_PASS, digits: 3'd0, code: 16'h0000};
            cnt_reg   <= 3'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (accept_in)
            begin
                state_reg <= state_next;
            end
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            list_reg <= list_next;
            tok_reg  <= last_byte;
        end
    end

    assign head       = list_reg[idx_reg];
    assign out_byte   = head.data;
    assign byte_valid = head.valid;
    assign bad_escape = head.err;
    assign run_end    = at_tail;
    assign token_end  = tok_reg;

endmodule

/* hdl/qsu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_checker
// Port-level checks for the quoted string unescape unit, bound to the top.
// ----------------------------------------------------------------------------
module qsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       bad_escape,
    input logic       run_end,
    input logic       token_end
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(byte_valid)
            && $stable(bad_escape) && $stable(run_end) && $stable(token_end))
        else $error("stalled output word changed");

    // input backpressure only while results are pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending output");

    // an escape error or an end marker carries a zero byte
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00)
        else $error("invalid output word carries data");

    a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_escape |-> !byte_valid)
        else $error("escape error flagged on a data word");

    // a bare end marker only closes a token
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid && !bad_escape |-> run_end && token_end)
        else $error("end marker outside the close of a token");

endmodule

bind quoted_string_unescape_utf8_unit qsu_checker u_qsu_checker (.*);
